### rtl/core/ttacc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttacc_pkg
// Shared types, codes and saturation helpers of the tangent accumulator.
// ----------------------------------------------------------------------------
package ttacc_pkg;

	localparam logic [1:0] ACT_LOAD = 2'd0;
	localparam logic [1:0] ACT_TRI  = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;

	// request kinds after classification in the front end
	typedef enum logic [2:0] {
		OP_LOAD,
		OP_READ,
		OP_READ_ZERO,
		OP_TRI,
		OP_TRI_SKIP
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [9:0]         slot;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] tex_u;
		logic signed [31:0] tex_v;
		logic [9:0]         corner_a;
		logic [9:0]         corner_b;
		logic [9:0]         corner_c;
	} req_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] tex_u;
		logic signed [31:0] tex_v;
	} vtx_t;

	// tangent x, y, z in lanes 0..2, bitangent x, y, z in lanes 3..5
	typedef logic [5:0][31:0] sums_t;

	typedef struct packed {
		logic [9:0]         result_slot;
		logic signed [31:0] tangent_x;
		logic signed [31:0] tangent_y;
		logic signed [31:0] tangent_z;
		logic signed [31:0] bitangent_x;
		logic signed [31:0] bitangent_y;
		logic signed [31:0] bitangent_z;
		logic               degenerate;
	} res_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_SUM,
		ST_RD_A,
		ST_RD_B,
		ST_RD_C,
		ST_DELTA,
		ST_DET_MUL,
		ST_DET_SUB,
		ST_DIV,
		ST_NUM_MUL,
		ST_NUM_SUB,
		ST_SCL_MUL,
		ST_SCL_SUM,
		ST_ACC_RD,
		ST_ACC_WR,
		ST_EMIT
	} state_t;

	// clip a 33-bit signed value to 32 bits
	function automatic logic signed [31:0] sat33(input logic signed [32:0] s);
		logic signed [31:0] r;
		if (s[32] != s[31]) begin
			r = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			r = s[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return sat33({a[31], a} + {b[31], b});
	endfunction

	function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return sat33({a[31], a} - {b[31], b});
	endfunction

	// apply a sign to a magnitude, clipping to signed 32 bits
	function automatic logic signed [31:0] sat_mag(input logic [63:0] m, input logic neg);
		logic signed [31:0] r;
		if (neg) begin
			r = (m >= 64'h8000_0000) ? 32'sh8000_0000 : -$signed(m[31:0]);
		end else begin
			r = (m >= 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(m[31:0]);
		end
		return r;
	endfunction

endpackage

### rtl/core/ttacc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttacc_front
// Accepts input items, classifies them and queues requests for the back end.
// ----------------------------------------------------------------------------
module ttacc_front import ttacc_pkg::*; #(
	parameter int MAX_VERTICES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         action,
	input  logic [9:0]         vertex_slot,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] tex_u,
	input  logic signed [31:0] tex_v,
	input  logic [9:0]         corner_a,
	input  logic [9:0]         corner_b,
	input  logic [9:0]         corner_c,
	input  logic               busy,
	output logic               req_valid,
	output req_t               req,
	input  logic               req_pop
);

	req_t       q_mem [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       keep;
	logic       enq;
	logic       deq;
	req_t       new_req;

	function automatic logic in_range(input logic [9:0] s);
		return 32'(s) < 32'(MAX_VERTICES);
	endfunction

	always_comb begin
		new_req.slot     = vertex_slot;
		new_req.pos_x    = pos_x;
		new_req.pos_y    = pos_y;
		new_req.pos_z    = pos_z;
		new_req.tex_u    = tex_u;
		new_req.tex_v    = tex_v;
		new_req.corner_a = corner_a;
		new_req.corner_b = corner_b;
		new_req.corner_c = corner_c;
		new_req.op       = OP_LOAD;
		keep             = 1'b0;
		unique case (action)
			ACT_LOAD: begin
				new_req.op = OP_LOAD;
				keep       = in_range(vertex_slot);
			end
			ACT_READ: begin
				new_req.op = in_range(vertex_slot) ? OP_READ : OP_READ_ZERO;
				keep       = 1'b1;
			end
			ACT_TRI: begin
				new_req.op = (in_range(corner_a) && in_range(corner_b) && in_range(corner_c))
					? OP_TRI : OP_TRI_SKIP;
				keep       = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign full      = (cnt_q == 2'd2) || busy;
	assign enq       = push && !full && keep;
	assign req_valid = (cnt_q != 2'd0);
	assign deq       = req_pop && req_valid;
	assign req       = q_mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (enq) wr_q <= !wr_q;
			if (deq) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(enq) - 2'(deq);
		end
	end

	always_ff @(posedge clk) begin
		if (enq) q_mem[wr_q] <= new_req;
	end

endmodule

### rtl/core/ttacc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttacc_div
// Radix-4 restoring divider for 2^48 / divisor, two quotient bits a cycle.
// ----------------------------------------------------------------------------
module ttacc_div import ttacc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] divisor,
	output logic        done,
	output logic [48:0] quotient
);

	localparam int QW    = 50;
	localparam int STEPS = QW / 2;

	logic [64:0]   rem_q;
	logic [QW-1:0] quo_q;
	logic [63:0]   dvs_q;
	logic [4:0]    cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [64:0]   rem_n;
	logic [QW-1:0] quo_n;

	always_comb begin
		rem_n = rem_q;
		quo_n = quo_q;
		for (int i = 0; i < 2; i++) begin
			rem_n = {rem_n[63:0], quo_n[QW-1]};
			quo_n = {quo_n[QW-2:0], 1'b0};
			if (rem_n >= {1'b0, dvs_q}) begin
				rem_n    = rem_n - {1'b0, dvs_q};
				quo_n[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= QW'(1) << 48;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q[48:0];

endmodule

### rtl/core/ttacc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttacc_back
// Sequencer with vertex and sum stores, shared multipliers and result queue.
// ----------------------------------------------------------------------------
module ttacc_back import ttacc_pkg::*; #(
	parameter int MAX_VERTICES = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  req_t req,
	output logic req_pop,
	output logic clearing,
	output res_t res,
	output logic empty,
	input  logic pop
);

	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

	vtx_t  vtx_mem [MAX_VERTICES];
	sums_t sum_mem [MAX_VERTICES];

	state_t state_q, state_n;

	logic          vtx_we;
	logic [AW-1:0] vtx_wa, vtx_ra;
	vtx_t          vtx_rd_q;
	logic          sum_we;
	logic [AW-1:0] sum_wa, sum_ra;
	sums_t         sum_wd;
	sums_t         sum_rd_q;

	logic [AW-1:0] clr_q;
	logic [2:0]    k_q;
	logic [1:0]    j_q;
	logic [1:0]    lane;
	logic [9:0]    corner_j;

	req_t               cur_q;
	logic               degen_q;
	vtx_t               va_q, vb_q;
	logic signed [31:0] dp1_q [3];
	logic signed [31:0] dp2_q [3];
	logic signed [31:0] du1_q, dv1_q, du2_q, dv2_q;
	logic signed [63:0] p0_q, p1_q;
	logic signed [32:0] m0_a, m0_b, m1_a, m1_b;
	logic signed [65:0] prod0, prod1;
	logic signed [64:0] diff;
	logic [63:0]        diff_mag;
	logic               neg_q;
	logic [31:0]        rmag_q;
	logic               rneg_q;
	logic signed [31:0] r_val;
	logic [63:0]        mn_q;
	logic               nneg_q;
	logic [63:0]        scl_q;
	logic signed [31:0] vec_q [6];

	logic        div_start;
	logic        div_done;
	logic [48:0] div_quo;

	res_t       oq [2];
	logic       owr_q, ord_q;
	logic [1:0] ocnt_q;
	logic       opush, opop;
	res_t       res_n;

	ttacc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (diff_mag),
		.done     (div_done),
		.quotient (div_quo)
	);

	// corner and lane selects
	always_comb begin
		lane = (k_q >= 3'd3) ? 2'(k_q - 3'd3) : k_q[1:0];
		unique case (j_q)
			2'd0:    corner_j = cur_q.corner_a;
			2'd1:    corner_j = cur_q.corner_b;
			default: corner_j = cur_q.corner_c;
		endcase
	end

	// shared multiplier operands
	always_comb begin
		m0_a = '0;
		m0_b = '0;
		m1_a = '0;
		m1_b = '0;
		priority case (state_q)
			ST_DET_MUL: begin
				m0_a = 33'(du1_q);
				m0_b = 33'(dv2_q);
				m1_a = 33'(dv1_q);
				m1_b = 33'(du2_q);
			end
			ST_NUM_MUL: begin
				if (k_q < 3'd3) begin
					m0_a = 33'(dp1_q[lane]);
					m0_b = 33'(dv2_q);
					m1_a = 33'(dp2_q[lane]);
					m1_b = 33'(dv1_q);
				end else begin
					m0_a = 33'(dp2_q[lane]);
					m0_b = 33'(du1_q);
					m1_a = 33'(dp1_q[lane]);
					m1_b = 33'(du2_q);
				end
			end
			ST_SCL_MUL: begin
				m0_a = $signed({1'b0, mn_q[63:32]});
				m0_b = $signed({1'b0, rmag_q});
				m1_a = $signed({1'b0, mn_q[31:0]});
				m1_b = $signed({1'b0, rmag_q});
			end
			default: begin
				m0_a = '0;
			end
		endcase
	end

	assign prod0    = m0_a * m0_b;
	assign prod1    = m1_a * m1_b;
	assign diff     = {p0_q[63], p0_q} - {p1_q[63], p1_q};
	assign diff_mag = diff[64] ? 64'(-diff) : diff[63:0];
	assign r_val    = sat_mag({15'd0, div_quo}, neg_q);
	assign scl_q    = 64'(p0_q) + {32'd0, p1_q[63:32]};

	// next state and memory controls
	always_comb begin
		state_n   = state_q;
		req_pop   = 1'b0;
		div_start = 1'b0;
		opush     = 1'b0;
		vtx_we    = 1'b0;
		vtx_wa    = AW'(req.slot);
		vtx_ra    = AW'(cur_q.corner_a);
		sum_we    = 1'b0;
		sum_wa    = AW'(req.slot);
		sum_wd    = '0;
		sum_ra    = AW'(cur_q.slot);
		unique case (state_q)
			ST_CLEAR: begin
				sum_we = 1'b1;
				sum_wa = clr_q;
				if (clr_q == AW'(MAX_VERTICES - 1)) state_n = ST_IDLE;
			end
			ST_IDLE: begin
				sum_ra = AW'(req.slot);
				if (req_valid) begin
					req_pop = 1'b1;
					unique case (req.op)
						OP_LOAD: begin
							vtx_we = 1'b1;
							sum_we = 1'b1;
						end
						OP_READ:      state_n = ST_RD_SUM;
						OP_TRI:       state_n = ST_RD_A;
						default:      state_n = ST_EMIT;
					endcase
				end
			end
			ST_RD_SUM:  state_n = ST_EMIT;
			ST_RD_A: begin
				vtx_ra  = AW'(cur_q.corner_a);
				state_n = ST_RD_B;
			end
			ST_RD_B: begin
				vtx_ra  = AW'(cur_q.corner_b);
				state_n = ST_RD_C;
			end
			ST_RD_C: begin
				vtx_ra  = AW'(cur_q.corner_c);
				state_n = ST_DELTA;
			end
			ST_DELTA:   state_n = ST_DET_MUL;
			ST_DET_MUL: state_n = ST_DET_SUB;
			ST_DET_SUB: begin
				if (diff == '0) begin
					state_n = ST_EMIT;
				end else begin
					div_start = 1'b1;
					state_n   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) state_n = ST_NUM_MUL;
			end
			ST_NUM_MUL: state_n = ST_NUM_SUB;
			ST_NUM_SUB: state_n = ST_SCL_MUL;
			ST_SCL_MUL: state_n = ST_SCL_SUM;
			ST_SCL_SUM: state_n = (k_q == 3'd5) ? ST_ACC_RD : ST_NUM_MUL;
			ST_ACC_RD: begin
				sum_ra  = AW'(corner_j);
				state_n = ST_ACC_WR;
			end
			ST_ACC_WR: begin
				sum_ra = AW'(corner_j);
				sum_we = 1'b1;
				sum_wa = AW'(corner_j);
				for (int e = 0; e < 6; e++) begin
					sum_wd[e] = sat_add($signed(sum_rd_q[e]), vec_q[e]);
				end
				state_n = (j_q == 2'd2) ? ST_EMIT : ST_ACC_RD;
			end
			ST_EMIT: begin
				if (ocnt_q != 2'd2) begin
					opush   = 1'b1;
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			k_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
			if (state_q == ST_IDLE) begin
				k_q <= '0;
				j_q <= '0;
			end
			if (state_q == ST_SCL_SUM) k_q <= k_q + 3'd1;
			if (state_q == ST_ACC_WR)  j_q <= j_q + 2'd1;
		end
	end

	// stores: one write and one registered read each
	always_ff @(posedge clk) begin
		if (vtx_we) begin
			vtx_mem[vtx_wa] <= '{pos_x: req.pos_x, pos_y: req.pos_y, pos_z: req.pos_z,
				tex_u: req.tex_u, tex_v: req.tex_v};
		end
		vtx_rd_q <= vtx_mem[vtx_ra];
	end

	always_ff @(posedge clk) begin
		if (sum_we) sum_mem[sum_wa] <= sum_wd;
		sum_rd_q <= sum_mem[sum_ra];
	end

	// datapath
	always_ff @(posedge clk) begin
		p0_q <= prod0[63:0];
		p1_q <= prod1[63:0];
		unique case (state_q)
			ST_IDLE: begin
				cur_q   <= req;
				degen_q <= (req.op == OP_TRI_SKIP);
			end
			ST_RD_B: va_q <= vtx_rd_q;
			ST_RD_C: vb_q <= vtx_rd_q;
			ST_DELTA: begin
				dp1_q[0] <= sat_sub(vb_q.pos_x, va_q.pos_x);
				dp1_q[1] <= sat_sub(vb_q.pos_y, va_q.pos_y);
				dp1_q[2] <= sat_sub(vb_q.pos_z, va_q.pos_z);
				dp2_q[0] <= sat_sub(vtx_rd_q.pos_x, va_q.pos_x);
				dp2_q[1] <= sat_sub(vtx_rd_q.pos_y, va_q.pos_y);
				dp2_q[2] <= sat_sub(vtx_rd_q.pos_z, va_q.pos_z);
				du1_q    <= sat_sub(vb_q.tex_u, va_q.tex_u);
				dv1_q    <= sat_sub(vb_q.tex_v, va_q.tex_v);
				du2_q    <= sat_sub(vtx_rd_q.tex_u, va_q.tex_u);
				dv2_q    <= sat_sub(vtx_rd_q.tex_v, va_q.tex_v);
			end
			ST_DET_SUB: begin
				neg_q   <= diff[64];
				degen_q <= (diff == '0);
			end
			ST_DIV: begin
				rneg_q <= r_val[31];
				rmag_q <= r_val[31] ? 32'(-r_val) : r_val;
			end
			ST_NUM_SUB: begin
				mn_q   <= diff_mag;
				nneg_q <= diff[64];
			end
			ST_SCL_SUM: vec_q[k_q] <= sat_mag(scl_q, nneg_q ^ rneg_q);
			default: begin
			end
		endcase
	end

	// result build and two-entry output queue
	always_comb begin
		res_n.result_slot = (cur_q.op == OP_READ || cur_q.op == OP_READ_ZERO)
			? cur_q.slot : cur_q.corner_a;
		res_n.degenerate  = degen_q && (cur_q.op != OP_READ) && (cur_q.op != OP_READ_ZERO);
		res_n.tangent_x   = '0;
		res_n.tangent_y   = '0;
		res_n.tangent_z   = '0;
		res_n.bitangent_x = '0;
		res_n.bitangent_y = '0;
		res_n.bitangent_z = '0;
		if (cur_q.op == OP_READ) begin
			res_n.tangent_x   = $signed(sum_rd_q[0]);
			res_n.tangent_y   = $signed(sum_rd_q[1]);
			res_n.tangent_z   = $signed(sum_rd_q[2]);
			res_n.bitangent_x = $signed(sum_rd_q[3]);
			res_n.bitangent_y = $signed(sum_rd_q[4]);
			res_n.bitangent_z = $signed(sum_rd_q[5]);
		end
	end

	assign empty    = (ocnt_q == 2'd0);
	assign opop     = pop && !empty;
	assign res      = oq[ord_q];
	assign clearing = (state_q == ST_CLEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= 1'b0;
			ord_q  <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (opush) owr_q <= !owr_q;
			if (opop)  ord_q <= !ord_q;
			ocnt_q <= ocnt_q + 2'(opush) - 2'(opop);
		end
	end

	always_ff @(posedge clk) begin
		if (opush) oq[owr_q] <= res_n;
	end

endmodule

### rtl/core/triangle_tangent_accumulator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_tangent_accumulator_top
// Per-triangle tangent and bitangent accumulation over a vertex store.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel is a queue: drive a request and raise push; it is taken
//   at a clock edge where push is high and full is low. Result channel is a
//   queue too: while empty is low the oldest result sits on the result
//   ports and is taken at an edge where pop is high.
//   A load request writes one vertex and clears its sums (no result). A
//   read request returns one vertex's sums. A triangle request adds its
//   tangent and bitangent to all three corners and returns a status with
//   degenerate set when it was skipped.
// Operation:
//   A triangle uses three vertex reads on the single store port, one shared
//   pair of multipliers stepped through the determinant, twelve numerator
//   products and twelve scaling products, a divider that holds the
//   sequencer for the reciprocal, and three read-modify-write passes on the
//   sum store; a zero determinant skips the divider, products and passes.
//   Items run one at a time.
// Reset:
//   After reset the sum store is swept to zero while full stays high. A
//   two-deep request queue and a two-deep result queue decouple the sides;
//   a stalled receiver backs up into full.
// ----------------------------------------------------------------------------
module triangle_tangent_accumulator_top import ttacc_pkg::*; #(
	parameter int MAX_VERTICES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         action,
	input  logic [9:0]         vertex_slot,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] tex_u,
	input  logic signed [31:0] tex_v,
	input  logic [9:0]         corner_a,
	input  logic [9:0]         corner_b,
	input  logic [9:0]         corner_c,
	output logic               empty,
	input  logic               pop,
	output logic [9:0]         result_slot,
	output logic signed [31:0] tangent_x,
	output logic signed [31:0] tangent_y,
	output logic signed [31:0] tangent_z,
	output logic signed [31:0] bitangent_x,
	output logic signed [31:0] bitangent_y,
	output logic signed [31:0] bitangent_z,
	output logic               degenerate
);

	// request queue between front and back
	logic req_valid;
	req_t req;
	logic req_pop;
	logic clearing;
	res_t res;

	// classify and queue incoming requests; hold full during the clear sweep
	ttacc_front #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.action      (action),
		.vertex_slot (vertex_slot),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.tex_u       (tex_u),
		.tex_v       (tex_v),
		.corner_a    (corner_a),
		.corner_b    (corner_b),
		.corner_c    (corner_c),
		.busy        (clearing),
		.req_valid   (req_valid),
		.req         (req),
		.req_pop     (req_pop)
	);

	// carry out requests and queue results
	ttacc_back #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_pop   (req_pop),
		.clearing  (clearing),
		.res       (res),
		.empty     (empty),
		.pop       (pop)
	);

	// drive result ports from the queue head
	assign result_slot = res.result_slot;
	assign tangent_x   = res.tangent_x;
	assign tangent_y   = res.tangent_y;
	assign tangent_z   = res.tangent_z;
	assign bitangent_x = res.bitangent_x;
	assign bitangent_y = res.bitangent_y;
	assign bitangent_z = res.bitangent_z;
	assign degenerate  = res.degenerate;

endmodule
